// ----- rtl/hst_pkg.sv -----
// Package for the handle slot table: sizes, request and response codes, and the
// request and response structs used on the ports. Depends on nothing.
package hst_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = 6;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [SLOT_W-1:0]  slot_index;
        logic [VALUE_W-1:0] entry_value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  placed_index;
        logic [VALUE_W-1:0] old_value;
        logic [COUNT_W-1:0] occupied;
    } t_rsp;

endpackage

// ----- rtl/hst_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module hst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/handle_slot_table.sv -----
// Handle slot table top level: request decode, occupancy bitmap, lowest free slot
// search and result register. Depends on hst_pkg and hst_ram.
//
// The slot value is read from the value RAM in the cycle a request is taken, and
// the update, the search for the next free slot and the write back happen in
// S_EXEC, which waits while the last response is still stalled; no new request is
// taken before that. A finished response waits in its own register, and the next
// request is taken meanwhile. The occupancy bits live in flip-flops, so reset, clear
// and a configuration write empty the table at once, with no clearing pass.
module handle_slot_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  hst_pkg::t_req               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output hst_pkg::t_rsp               o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hst_pkg::COUNT_W-1:0] i_cfg_data
);

    import hst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    t_req                     r_req;
    logic [TABLE_SLOTS-1:0]   r_full, n_full;
    logic [COUNT_W-1:0]       r_occ, n_occ;
    logic [COUNT_W-1:0]       r_lowest, n_lowest;
    logic [COUNT_W-1:0]       r_act, n_act;
    logic                     r_out_valid, n_out_valid;
    t_rsp                     r_out, n_out;

    logic                     in_accept;
    logic                     cfg_accept;
    logic                     commit;
    logic                     ram_we;
    logic [SLOT_W-1:0]        ram_waddr;
    logic [VALUE_W-1:0]       ram_rdata;
    logic [COUNT_W-1:0]       idx_ext;
    logic [COUNT_W-1:0]       search_start;
    logic                     search_en;

    function automatic logic [COUNT_W-1:0] first_free(
        input logic [TABLE_SLOTS-1:0] free,
        input logic [COUNT_W-1:0]     start,
        input logic [COUNT_W-1:0]     act
    );
        logic [TABLE_SLOTS-1:0] cand;
        logic [TABLE_SLOTS-1:0] first;
        logic [COUNT_W-1:0]     pos;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            cand[i] = free[i] && (COUNT_W'(i) >= start) && (COUNT_W'(i) < act);
        end
        first = cand & (~cand + TABLE_SLOTS'(1));
        pos   = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            pos = pos | (first[i] ? COUNT_W'(i) : '0);
        end
        return (|cand) ? pos : act;
    endfunction

    assign in_accept   = i_in_valid && !o_in_stall;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign commit      = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign idx_ext     = {1'b0, r_req.slot_index};

    hst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_SLOTS)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req.entry_value),
        .i_re    (in_accept),
        .i_raddr (i_in.slot_index),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_full       = r_full;
        n_occ        = r_occ;
        n_lowest     = r_lowest;
        n_act        = r_act;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        ram_we       = 1'b0;
        ram_waddr    = r_req.slot_index;
        search_en    = 1'b0;
        search_start = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state              = S_IDLE;
                    n_out_valid          = 1'b1;
                    n_out.status         = ST_OK;
                    n_out.placed_index   = '0;
                    n_out.old_value      = '0;
                    unique case (r_req.cmd)
                        CMD_INSERT: begin
                            if (r_req.entry_value == '0) begin
                                n_out.status = ST_BAD_ARG;
                            end else if (r_occ >= r_act || r_lowest >= r_act) begin
                                n_out.status = ST_FULL;
                            end else begin
                                ram_we                     = 1'b1;
                                ram_waddr                  = r_lowest[SLOT_W-1:0];
                                n_full[r_lowest[SLOT_W-1:0]] = 1'b1;
                                n_occ                      = r_occ + 1'b1;
                                n_out.placed_index         = r_lowest[SLOT_W-1:0];
                                search_en                  = 1'b1;
                                search_start               = r_lowest + 1'b1;
                            end
                        end
                        CMD_SET: begin
                            if (r_req.entry_value == '0 || idx_ext >= r_act) begin
                                n_out.status = ST_BAD_ARG;
                            end else begin
                                ram_we = 1'b1;
                                if (!r_full[r_req.slot_index]) begin
                                    n_occ = r_occ + 1'b1;
                                end
                                n_full[r_req.slot_index] = 1'b1;
                                if (idx_ext == r_lowest) begin
                                    search_en    = 1'b1;
                                    search_start = idx_ext + 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (idx_ext >= r_act) begin
                                n_out.status = ST_BAD_ARG;
                            end else if (r_full[r_req.slot_index]) begin
                                n_out.old_value          = ram_rdata;
                                n_full[r_req.slot_index] = 1'b0;
                                n_occ                    = r_occ - 1'b1;
                                if (idx_ext < r_lowest) begin
                                    n_lowest = idx_ext;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_full   = '0;
                            n_occ    = '0;
                            n_lowest = '0;
                        end
                        default: begin
                            n_out.status = ST_BAD_ARG;
                        end
                    endcase
                    if (search_en) begin
                        n_lowest = (n_occ >= r_act) ? r_act
                                 : first_free(~n_full, search_start, r_act);
                    end
                    n_out.occupied = n_occ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_accept) begin
            if (i_cfg_data == '0) begin
                n_act = COUNT_W'(1);
            end else if (i_cfg_data > COUNT_W'(TABLE_SLOTS)) begin
                n_act = COUNT_W'(TABLE_SLOTS);
            end else begin
                n_act = i_cfg_data;
            end
            n_full   = '0;
            n_occ    = '0;
            n_lowest = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_full      <= '0;
            r_occ       <= '0;
            r_lowest    <= '0;
            r_act       <= COUNT_W'(TABLE_SLOTS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_full      <= n_full;
            r_occ       <= n_occ;
            r_lowest    <= n_lowest;
            r_act       <= n_act;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in;
        end
        r_out <= n_out;
    end

    a_count_matches_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_full) == 32'(r_occ))
        else $error("Occupancy count disagrees with the occupancy bitmap.");

    a_count_within_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= r_act && r_lowest <= r_act)
        else $error("Occupancy or lowest free slot exceeds the active size.");

    a_lowest_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lowest < r_act |-> !r_full[r_lowest[SLOT_W-1:0]])
        else $error("Lowest free slot points at an occupied slot.");

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_EXEC && o_in_stall)
        else $error("Accepted request did not enter the update cycle.");

endmodule

// ----- test/hst_checker.sv -----
// Checker for the handle slot table: watches the request, response and configuration
// channels, predicts each response from its own copy of the table and compares them.
// Depends on hst_pkg.
module hst_checker
    import hst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_req               i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_rsp               i_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [VALUE_W-1:0]     slot_value [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] slot_taken;
    int unsigned            taken_count;
    int unsigned            first_free;
    logic [COUNT_W-1:0]     slot_limit;
    t_rsp                   table_rsp_q [$];
    int                     mismatches = 0;
    int                     queued_rsps = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = queued_rsps;

    function automatic int unsigned live_slots();
        if (slot_limit == '0) begin
            return 1;
        end
        if (slot_limit > TABLE_SLOTS) begin
            return TABLE_SLOTS;
        end
        return slot_limit;
    endfunction

    function automatic void empty_slots();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_value[i] = '0;
        end
        slot_taken  = '0;
        taken_count = 0;
        first_free  = 0;
    endfunction

    // Lowest free slot at or above start, or the active size when there is none.
    function automatic int unsigned free_slot_from(input int unsigned start);
        int unsigned act;
        act = live_slots();
        if (taken_count >= act) begin
            return act;
        end
        for (int unsigned i = start; i < act; i++) begin
            if (!slot_taken[i]) begin
                return i;
            end
        end
        return act;
    endfunction

    function automatic t_rsp apply_table_request(input t_req req);
        t_rsp               rsp;
        int unsigned        act;
        int unsigned        at;
        int unsigned        idx;
        logic [VALUE_W-1:0] val;
        rsp = '0;
        act = live_slots();
        idx = req.slot_index;
        val = req.entry_value;
        case (req.cmd)
            CMD_INSERT: begin
                if (val == '0) begin
                    rsp.status = ST_BAD_ARG;
                end else if (taken_count >= act || first_free >= act) begin
                    rsp.status = ST_FULL;
                end else begin
                    at = first_free;
                    slot_value[at] = val;
                    slot_taken[at] = 1'b1;
                    taken_count++;
                    rsp.placed_index = SLOT_W'(at);
                    first_free = free_slot_from(at + 1);
                end
            end
            CMD_SET: begin
                if (val == '0 || idx >= act) begin
                    rsp.status = ST_BAD_ARG;
                end else begin
                    if (!slot_taken[idx]) begin
                        taken_count++;
                    end
                    slot_value[idx] = val;
                    slot_taken[idx] = 1'b1;
                    if (idx == first_free) begin
                        first_free = free_slot_from(idx + 1);
                    end
                end
            end
            CMD_REMOVE: begin
                if (idx >= act) begin
                    rsp.status = ST_BAD_ARG;
                end else if (slot_taken[idx]) begin
                    rsp.old_value = slot_value[idx];
                    slot_value[idx] = '0;
                    slot_taken[idx] = 1'b0;
                    taken_count--;
                    if (idx < first_free) begin
                        first_free = idx;
                    end
                end
            end
            default: begin
                empty_slots();
            end
        endcase
        rsp.occupied = COUNT_W'(taken_count);
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        if (!i_rst_n) begin
            slot_limit = COUNT_W'(TABLE_SLOTS);
            empty_slots();
            table_rsp_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                slot_limit = i_cfg_data;
                empty_slots();
            end
            if (i_out_valid && !i_out_stall) begin
                if (table_rsp_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: response with none outstanding, expected nothing, actual %h",
                             $time, i_out);
                end else begin
                    want = table_rsp_q.pop_front();
                    check_field("status", VALUE_W'(want.status), VALUE_W'(i_out.status));
                    check_field("placed_index", VALUE_W'(want.placed_index),
                                VALUE_W'(i_out.placed_index));
                    check_field("old_value", want.old_value, i_out.old_value);
                    check_field("occupied", VALUE_W'(want.occupied), VALUE_W'(i_out.occupied));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                table_rsp_q.push_back(apply_table_request(i_in));
            end
        end
        queued_rsps = table_rsp_q.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the handle slot table: clock, reset, request and configuration
// stimulus, response stalls and the verdict. Depends on hst_pkg, handle_slot_table
// and hst_checker.
module tb_top;
    import hst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 125;
    localparam int LONG_HOLD   = 120;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_req               in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_rsp               out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;
    int                 fail_count;
    int                 pending;

    int unsigned        act_slots = TABLE_SLOTS;
    bit                 in_idle_on = 1'b1;
    bit                 out_idle_on = 1'b1;
    int unsigned        hold_requests = 0;
    logic [COUNT_W-1:0] phase_limits [PHASE_COUNT];

    handle_slot_table u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    hst_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned pick_idle_length();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input t_req req);
        int unsigned gap;
        gap = 0;
        if (in_idle_on && $urandom_range(0, 99) < 35) begin
            gap = pick_idle_length();
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_fields(input t_cmd cmd, input int unsigned idx,
                               input logic [VALUE_W-1:0] val);
        t_req req;
        req.cmd         = cmd;
        req.slot_index  = SLOT_W'(idx);
        req.entry_value = val;
        send_request(req);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [COUNT_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        act_slots = (value == '0) ? 1 : ((value > TABLE_SLOTS) ? TABLE_SLOTS : value);
    endtask

    function automatic t_req random_request(input bit filling);
        t_req        req;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            req.cmd = CMD_CLEAR;
        end else if (r < (filling ? 60 : 25)) begin
            req.cmd = CMD_INSERT;
        end else if (r < (filling ? 80 : 40)) begin
            req.cmd = CMD_SET;
        end else begin
            req.cmd = CMD_REMOVE;
        end
        if ($urandom_range(0, 99) < 85) begin
            req.slot_index = SLOT_W'($urandom_range(0, act_slots - 1));
        end else begin
            req.slot_index = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            req.entry_value = '0;
        end else if (r < 10) begin
            req.entry_value = '1;
        end else if (r < 15) begin
            req.entry_value = VALUE_W'($urandom_range(1, 15));
        end else begin
            req.entry_value = $urandom();
        end
        return req;
    endfunction

    // The response side stalls at random, and for one long stretch when asked.
    initial begin : out_stall_gen
        int unsigned stall_left;
        int unsigned served;
        stall_left = 0;
        served = 0;
        forever begin
            @(posedge clk);
            if (hold_requests != served) begin
                served = hold_requests;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && out_idle_on && $urandom_range(0, 99) < 30) begin
                stall_left = pick_idle_length();
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        phase_limits = '{7'd64, 7'd5, 7'd127, 7'd1, 7'd32, 7'd0, 7'd2, 7'd64, 7'd65, 7'd17};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(CMD_INSERT, 0, '0);
        send_fields(CMD_INSERT, 0, 32'hFFFF_FFFF);
        send_fields(CMD_INSERT, 63, 32'h0000_0001);
        send_fields(CMD_SET, 63, 32'h8000_0000);
        send_fields(CMD_SET, 5, '0);
        send_fields(CMD_SET, 2, 32'h55AA_55AA);
        send_fields(CMD_REMOVE, 1, 32'h1234_5678);
        send_fields(CMD_REMOVE, 1, '0);
        send_fields(CMD_INSERT, 0, 32'h1234_5678);
        send_fields(CMD_REMOVE, 63, '1);
        send_fields(CMD_CLEAR, 0, '0);
        send_fields(CMD_REMOVE, 0, '0);

        write_slot_count(7'd2);
        send_fields(CMD_INSERT, 0, 32'hA5A5_0001);
        send_fields(CMD_INSERT, 0, 32'h5A5A_0002);
        send_fields(CMD_INSERT, 0, 32'h0000_0003);
        send_fields(CMD_SET, 2, 32'h0000_0004);
        send_fields(CMD_REMOVE, 63, '0);
        send_fields(CMD_REMOVE, 0, '0);
        send_fields(CMD_SET, 0, 32'h0000_0005);
        send_fields(CMD_INSERT, 0, 32'h0000_0006);
        send_fields(CMD_REMOVE, 1, '0);
        send_fields(CMD_INSERT, 0, 32'h0000_0007);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_slot_count(phase_limits[p]);
            in_idle_on = (p % 3) != 0;
            out_idle_on <= (p % 3) != 0;
            if (p == 0) begin
                hold_requests <= hold_requests + 1;
                repeat (20) send_request(random_request(1'b1));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                send_request(random_request((n / 24) % 2 == 0));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hst_pkg.sv
rtl/hst_ram.sv
rtl/handle_slot_table.sv
test/hst_checker.sv
test/tb_top.sv
